>>> hw/rtl/ep2civ_pkg.sv
// Shared field widths and field types for the epoch-seconds to civil-time unit.
// No dependencies. Used by the channel interfaces, the top level and the checker.

package ep2civ_pkg;

  // Widths of the result fields.
  localparam int YEAR_W    = 17;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int SECOND_W  = 6;
  localparam int WEEKDAY_W = 3;

  // Field types, one per result field.
  typedef logic signed [YEAR_W-1:0] year_t;
  typedef logic [MONTH_W-1:0]       month_t;
  typedef logic [DAY_W-1:0]         day_t;
  typedef logic [HOUR_W-1:0]        hour_t;
  typedef logic [MINUTE_W-1:0]      minute_t;
  typedef logic [SECOND_W-1:0]      second_t;
  typedef logic [WEEKDAY_W-1:0]     weekday_t;

endpackage

>>> hw/rtl/ep2civ_ifs.sv
// Valid/ready channel interfaces: the timestamp input channel and the civil-time result channel.
// Depends on ep2civ_pkg for the result field types.

interface ep2civ_stamp_if #(
  parameter int SECONDS_WIDTH = 41
);
  logic                            valid;
  logic                            ready;
  logic signed [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ep2civ_civil_if
  import ep2civ_pkg::*;
();
  logic     valid;
  logic     ready;
  year_t    year;
  month_t   month;
  day_t     day;
  hour_t    hour;
  minute_t  minute;
  second_t  second;
  weekday_t weekday;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output weekday, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input weekday, output ready);
endinterface

>>> hw/rtl/epoch_seconds_to_civil_time_unit.sv
// Top level: converts signed epoch seconds into Gregorian date, time of day and weekday.
// Depends on ep2civ_pkg, ep2civ_ifs (channel interfaces) and ep2civ_cdiv.
//
//   channel  dir  word                               handshake
//   -------  ---  ---------------------------------  -----------
//   stamp    in   epoch_seconds (SECONDS_WIDTH, s)   valid/ready
//   civil    out  year month day hour minute second  valid/ready
//                 weekday
//
// One word is accepted per cycle unless a held result on civil has filled every
// stage. The two constant dividers (by 675 for days, by 146097 for eras) take
// two stages per digit.
// Synchronous reset empties the pipeline; data registers are not cleared.
// A result held on civil stalls only the stages behind it: empty stages keep
// filling, so stamp stays ready until every stage holds a word.

module epoch_seconds_to_civil_time_unit
  import ep2civ_pkg::*;
#(
  parameter int SECONDS_WIDTH = 41
) (
  input logic                  clk,
  input logic                  rst,
  ep2civ_stamp_if.sink         stamp,
  ep2civ_civil_if.source       civil
);

  localparam int W     = SECONDS_WIDTH;
  localparam int UW    = W - 8;          // magnitude of seconds / 128
  localparam int DAYW  = W - 16;         // signed day number
  localparam int ZW    = DAYW + 4;       // signed day number shifted to 0000-03-01
  localparam int ERAW  = ZW - 1;         // magnitude of the shifted day number

  localparam int SECS_DIV        = 675;    // 86400 / 128
  localparam int DAYS_PER_ERA    = 146097;
  localparam int SHIFT_TO_MARCH0 = 719468;
  localparam int DAY_RW          = $clog2(SECS_DIV);
  localparam int ERA_RW          = $clog2(DAYS_PER_ERA);

  // Reciprocals for the small constant divisions of the date and time-of-day stages.
  localparam int D_1460 = 1460;
  localparam int D_365  = 365;
  localparam int D_153  = 153;
  localparam int D_3600 = 3600;
  localparam int D_60   = 60;
  localparam int K_1460 = 29;
  localparam int K_365  = 27;
  localparam int K_153  = 19;
  localparam int K_3600 = 29;
  localparam int K_60   = 18;
  localparam logic [18:0] RCP_1460 =
    19'(((64'd1 << K_1460) + 64'(D_1460) - 64'd1) / 64'(D_1460));
  localparam logic [18:0] RCP_365 =
    19'(((64'd1 << K_365) + 64'(D_365) - 64'd1) / 64'(D_365));
  localparam logic [11:0] RCP_153 =
    12'(((64'd1 << K_153) + 64'(D_153) - 64'd1) / 64'(D_153));
  localparam logic [17:0] RCP_3600 =
    18'(((64'd1 << K_3600) + 64'(D_3600) - 64'd1) / 64'(D_3600));
  localparam logic [12:0] RCP_60 =
    13'(((64'd1 << K_60) + 64'(D_60) - 64'd1) / 64'(D_60));

  // First day of year, counted from March, for each March-based month.
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Stage valids and advance enables.
  logic v0, v1, v2, v3, v4, v5, v6, v7;
  logic en0, en1, en2, en3, en4, en5, en6, en7;

  // Divider handshakes and results.
  logic              d1_num_ready, d1_res_valid;
  logic [UW-1:0]     d1_quo;
  logic [DAY_RW-1:0] d1_rem;
  logic [7:0]        d1_tag;
  logic              d2_num_ready, d2_res_valid;
  logic [ERAW-1:0]   d2_quo;
  logic [ERA_RW-1:0] d2_rem;
  logic [17:0]       d2_tag;

  // Stage 0: input register.
  logic [W-1:0]      sec_r;
  logic              neg0;
  logic [UW-1:0]     mag0;

  // Stage 1: day number and second of day.
  logic [DAYW-1:0]   days1, days1_next;
  logic [16:0]       sod1, sod1_next;
  logic [DAY_RW-1:0] rday;
  logic [ZW-1:0]     z1;
  logic [ERAW-1:0]   mag1;

  // Stage 2: low bits of the era and day of era.
  logic [YEAR_W-1:0] era2, era2_next;
  logic [17:0]       doe2, doe2_next;
  logic [16:0]       sod2;

  // Stage 3 to stage 6 working values.
  logic [17:0]       a3, doe3, doe4;
  logic [YEAR_W-1:0] eray3, eray4, eray5, eray6;
  logic [2:0]        wd3, wd4, wd5, wd6;
  logic [4:0]        hour3, hour4, hour5, hour6;
  logic [16:0]       sod3;
  logic [8:0]        yoe4, yoe5, yoe6;
  logic [11:0]       remh4, remh5;
  logic [8:0]        doy5, doy6;
  logic [5:0]        min5, min6, sec6;
  logic [3:0]        mp6;

  // Combinational values between stages.
  logic [36:0]       p1460;
  logic [6:0]        d1460;
  logic [2:0]        c36524;
  logic [17:0]       a3_next;
  logic [17:0]       w7;
  logic [5:0]        fold_s;
  logic [3:0]        fold_s2;
  logic [2:0]        wd3_next;
  logic [34:0]       p3600;
  logic [36:0]       p365;
  logic [16:0]       remh_full;
  logic [1:0]        c100;
  logic [17:0]       yr_days;
  logic [17:0]       doy_full;
  logic [24:0]       p60;
  logic [10:0]       v153;
  logic [22:0]       p153;
  logic [5:0]        sec_full;
  logic [8:0]        day_full;
  logic [3:0]        month_next;

  // Output register.
  year_t    year_r;
  month_t   month_r;
  day_t     day_r;
  hour_t    hour_r;
  minute_t  minute_r;
  second_t  second_r;
  weekday_t weekday_r;

  // Advance chain, from the output back to the input.
  assign en7          = !v7 || civil.ready;
  assign en6          = !v6 || en7;
  assign en5          = !v5 || en6;
  assign en4          = !v4 || en5;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || d2_num_ready;
  assign en0          = !v0 || d1_num_ready;
  assign stamp.ready  = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en0) v0 <= stamp.valid;
      if (en1) v1 <= d1_res_valid;
      if (en2) v2 <= d2_res_valid;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // Stage 0: split seconds into a multiple of 128 and a low part. A negative
  // quotient is divided as its one's complement, which turns floor division
  // into plain unsigned division.
  always_ff @(posedge clk) begin
    if (en0) begin
      sec_r <= stamp.epoch_seconds;
    end
  end

  assign neg0 = sec_r[W-1];
  assign mag0 = neg0 ? ~sec_r[W-2:7] : sec_r[W-2:7];

  ep2civ_cdiv #(
    .DW      (UW),
    .DIVISOR (SECS_DIV),
    .DIGW    (16),
    .SW      (8)
  ) u_day_div (
    .clk       (clk),
    .rst       (rst),
    .num_valid (v0),
    .num_ready (d1_num_ready),
    .num       (mag0),
    .num_tag   ({neg0, sec_r[6:0]}),
    .res_valid (d1_res_valid),
    .res_ready (en1),
    .quo       (d1_quo),
    .rem       (d1_rem),
    .res_tag   (d1_tag)
  );

  // Stage 1: undo the complement to get the floored day and second of day.
  assign rday       = d1_tag[7] ? DAY_RW'(SECS_DIV - 1) - d1_rem : d1_rem;
  assign days1_next = d1_tag[7] ? ~d1_quo[DAYW-1:0] : d1_quo[DAYW-1:0];
  assign sod1_next  = {rday, d1_tag[6:0]};

  always_ff @(posedge clk) begin
    if (en1) begin
      days1 <= days1_next;
      sod1  <= sod1_next;
    end
  end

  // Shift the day number to start on 0000-03-01, then floor-divide into eras.
  assign z1   = {{(ZW-DAYW){days1[DAYW-1]}}, days1} + ZW'(SHIFT_TO_MARCH0);
  assign mag1 = z1[ZW-1] ? ~z1[ZW-2:0] : z1[ZW-2:0];

  ep2civ_cdiv #(
    .DW      (ERAW),
    .DIVISOR (DAYS_PER_ERA),
    .DIGW    (14),
    .SW      (18)
  ) u_era_div (
    .clk       (clk),
    .rst       (rst),
    .num_valid (v1),
    .num_ready (d2_num_ready),
    .num       (mag1),
    .num_tag   ({z1[ZW-1], sod1}),
    .res_valid (d2_res_valid),
    .res_ready (en2),
    .quo       (d2_quo),
    .rem       (d2_rem),
    .res_tag   (d2_tag)
  );

  // Stage 2: era (only the bits that reach the year) and day of era.
  assign era2_next = d2_tag[17] ? ~d2_quo[YEAR_W-1:0] : d2_quo[YEAR_W-1:0];
  assign doe2_next = d2_tag[17] ? ERA_RW'(DAYS_PER_ERA - 1) - d2_rem : d2_rem;

  always_ff @(posedge clk) begin
    if (en2) begin
      era2 <= era2_next;
      doe2 <= doe2_next;
      sod2 <= d2_tag[16:0];
    end
  end

  // Stage 3: leap-day corrections of the day of era, era times 400, the
  // weekday by folding octal digits (8 is 1 mod 7), and the hour.
  assign p1460   = 37'(doe2) * 37'(RCP_1460);
  assign d1460   = p1460[K_1460 +: 7];
  assign c36524  = 3'(doe2 >= 18'd36524) + 3'(doe2 >= 18'd73048)
                 + 3'(doe2 >= 18'd109572) + 3'(doe2 >= 18'd146096);
  assign a3_next = doe2 - 18'(d1460) + 18'(c36524) - 18'(doe2 == 18'd146096);

  assign w7       = doe2 + 18'd3;
  assign fold_s   = 6'(w7[2:0]) + 6'(w7[5:3]) + 6'(w7[8:6])
                  + 6'(w7[11:9]) + 6'(w7[14:12]) + 6'(w7[17:15]);
  assign fold_s2  = 4'(fold_s[5:3]) + 4'(fold_s[2:0]);
  assign wd3_next = (fold_s2 >= 4'd7) ? 3'(fold_s2 - 4'd7) : fold_s2[2:0];

  assign p3600 = 35'(sod2) * 35'(RCP_3600);

  always_ff @(posedge clk) begin
    if (en3) begin
      a3    <= a3_next;
      doe3  <= doe2;
      eray3 <= (era2 << 8) + (era2 << 7) + (era2 << 4);
      wd3   <= wd3_next;
      hour3 <= p3600[K_3600 +: 5];
      sod3  <= sod2;
    end
  end

  // Stage 4: year of era, and seconds left within the hour.
  assign p365      = 37'(a3) * 37'(RCP_365);
  assign remh_full = sod3 - 17'(hour3) * 17'(D_3600);

  always_ff @(posedge clk) begin
    if (en4) begin
      yoe4  <= p365[K_365 +: 9];
      doe4  <= doe3;
      eray4 <= eray3;
      wd4   <= wd3;
      hour4 <= hour3;
      remh4 <= remh_full[11:0];
    end
  end

  // Stage 5: day of the March-based year, and the minute.
  assign c100     = 2'(yoe4 >= 9'd100) + 2'(yoe4 >= 9'd200) + 2'(yoe4 >= 9'd300);
  assign yr_days  = 18'(yoe4) * 18'(D_365) + 18'(yoe4 >> 2) - 18'(c100);
  assign doy_full = doe4 - yr_days;
  assign p60      = 25'(remh4) * 25'(RCP_60);

  always_ff @(posedge clk) begin
    if (en5) begin
      doy5  <= doy_full[8:0];
      yoe5  <= yoe4;
      eray5 <= eray4;
      wd5   <= wd4;
      hour5 <= hour4;
      remh5 <= remh4;
      min5  <= p60[K_60 +: 6];
    end
  end

  // Stage 6: March-based month, and the second.
  assign v153     = 11'(doy5) * 11'd5 + 11'd2;
  assign p153     = 23'(v153) * 23'(RCP_153);
  assign sec_full = 6'(remh5 - 12'(min5) * 12'(D_60));

  always_ff @(posedge clk) begin
    if (en6) begin
      mp6   <= p153[K_153 +: 4];
      doy6  <= doy5;
      yoe6  <= yoe5;
      eray6 <= eray5;
      wd6   <= wd5;
      hour6 <= hour5;
      min6  <= min5;
      sec6  <= sec_full;
    end
  end

  // Stage 7: day of month, calendar month, and the year, which moves up by
  // one for January and February.
  assign day_full   = doy6 - mp_start(mp6) + 9'd1;
  assign month_next = (mp6 < 4'd10) ? mp6 + 4'd3 : mp6 - 4'd9;

  always_ff @(posedge clk) begin
    if (en7) begin
      year_r    <= year_t'(YEAR_W'(yoe6) + eray6 + YEAR_W'(month_next <= 4'd2));
      month_r   <= month_next;
      day_r     <= day_full[DAY_W-1:0];
      hour_r    <= hour6;
      minute_r  <= min6;
      second_r  <= sec6;
      weekday_r <= wd6;
    end
  end

  assign civil.valid   = v7;
  assign civil.year    = year_r;
  assign civil.month   = month_r;
  assign civil.day     = day_r;
  assign civil.hour    = hour_r;
  assign civil.minute  = minute_r;
  assign civil.second  = second_r;
  assign civil.weekday = weekday_r;

endmodule

>>> hw/rtl/ep2civ_cdiv.sv
// Pipelined divider of an unsigned number by a constant, one digit per stage pair.
// No dependencies. Used twice by the top level (seconds to days, days to 400-year eras).

module ep2civ_cdiv #(
  parameter int DW      = 33,
  parameter int DIVISOR = 675,
  parameter int DIGW    = 16,
  parameter int SW      = 8,
  localparam int RW     = $clog2(DIVISOR)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          num_valid,
  output logic          num_ready,
  input  logic [DW-1:0] num,
  input  logic [SW-1:0] num_tag,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [DW-1:0] quo,
  output logic [RW-1:0] rem,
  output logic [SW-1:0] res_tag
);

  localparam int ND  = (DW + DIGW - 1) / DIGW;
  localparam int PW  = ND * DIGW;
  localparam int TW  = RW + DIGW;
  localparam int K   = TW + RW;
  localparam int PRW = 2 * TW + 1;
  localparam int NS  = 2 * ND;
  // Rounded-up reciprocal; exact for every partial dividend below 2**TW.
  localparam logic [63:0] MULT_FULL =
    ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [TW:0]   MULT  = MULT_FULL[TW:0];
  localparam logic [TW-1:0] DIV_T = TW'(DIVISOR);

  logic [NS-1:0]  vld;
  logic [NS:0]    en;

  // Stage A of each digit: partial remainder and the digit to divide.
  logic [PW-1:0]  a_num  [ND];
  logic [PW-1:0]  a_quo  [ND];
  logic [RW-1:0]  a_rem  [ND];
  logic [SW-1:0]  a_tag  [ND];
  // Stage B of each digit: quotient digit found, remainder still to form.
  logic [PW-1:0]  b_num  [ND];
  logic [PW-1:0]  b_quo  [ND];
  logic [TW-1:0]  b_t    [ND];
  logic [SW-1:0]  b_tag  [ND];
  logic [RW-1:0]  b_rem  [ND];

  // Each stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NS] = res_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= num_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_dig
    localparam int MSB = PW - 1 - j * DIGW;

    logic [TW-1:0]   t;
    logic [PRW-1:0]  prod;
    logic [DIGW-1:0] qd;
    logic [PW-1:0]   quo_ins;

    // Quotient digit by reciprocal multiplication of the partial dividend.
    assign t    = {a_rem[j], a_num[j][MSB -: DIGW]};
    assign prod = PRW'(t) * PRW'(MULT);
    assign qd   = prod[K +: DIGW];

    always_comb begin
      quo_ins              = a_quo[j];
      quo_ins[MSB -: DIGW] = qd;
    end

    always_ff @(posedge clk) begin
      if (en[2*j+1]) begin
        b_num[j] <= a_num[j];
        b_quo[j] <= quo_ins;
        b_t[j]   <= t;
        b_tag[j] <= a_tag[j];
      end
    end

    // Remainder left over for the next digit.
    assign b_rem[j] = RW'(b_t[j] - TW'(b_quo[j][MSB -: DIGW]) * DIV_T);

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[0]) begin
          a_num[0] <= PW'(num);
          a_quo[0] <= '0;
          a_rem[0] <= '0;
          a_tag[0] <= num_tag;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[2*j]) begin
          a_num[j] <= b_num[j-1];
          a_quo[j] <= b_quo[j-1];
          a_rem[j] <= b_rem[j-1];
          a_tag[j] <= b_tag[j-1];
        end
      end
    end
  end

  assign num_ready = en[0];
  assign res_valid = vld[NS-1];
  assign quo       = b_quo[ND-1][DW-1:0];
  assign rem       = b_rem[ND-1];
  assign res_tag   = b_tag[ND-1];

endmodule

>>> hw/rtl/ep2civ_checker.sv
// Port-level checker for epoch_seconds_to_civil_time_unit, with its bind statement.
// Depends on ep2civ_pkg for the result field types.

module ep2civ_checker
  import ep2civ_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input year_t    year,
  input month_t   month,
  input day_t     day,
  input hour_t    hour,
  input minute_t  minute,
  input second_t  second,
  input weekday_t weekday
);

  logic       in_acc, out_acc;
  logic [7:0] pending, pending_next;

  // Count of words accepted whose result has not been taken yet.
  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid && out_ready;
  assign pending_next = pending + 8'(in_acc) - 8'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  // Every result field but the year lies in its calendar range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
                   hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6))
    else $error("result field out of range");

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({year, month, day, hour, minute, second, weekday}))
    else $error("stalled result changed");

  // No result appears without a word in flight.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result without an accepted word");

  // An empty unit always takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    pending == 8'd0 |-> in_ready)
    else $error("empty unit not ready");

endmodule

bind epoch_seconds_to_civil_time_unit ep2civ_checker u_ep2civ_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stamp.valid),
  .in_ready  (stamp.ready),
  .out_valid (civil.valid),
  .out_ready (civil.ready),
  .year      (civil.year),
  .month     (civil.month),
  .day       (civil.day),
  .hour      (civil.hour),
  .minute    (civil.minute),
  .second    (civil.second),
  .weekday   (civil.weekday)
);
